>>> design/arng_pkg.sv
// Shared types and constants for the auto-ranging axis tracker.
package arng_pkg;

    // Output bound width and coefficient width.
    localparam int OUT_W       = 26;
    localparam int COEF_W      = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int OUT_TDATA_W = ((2 * OUT_W + 7) / 8) * 8;

    // Register map of the configuration channel.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_HALF_SPAN = 2'd0,
        CFG_MIN_SPAN        = 2'd1,
        CFG_DECAY_COEF      = 2'd2,
        CFG_MARGIN_COEF     = 2'd3
    } cfg_reg_t;

    // Register reset values.
    localparam logic [CFG_DATA_W-1:0] RST_START_HALF_SPAN = 16'd50;
    localparam logic [CFG_DATA_W-1:0] RST_MIN_SPAN        = 16'd50;
    localparam logic [CFG_DATA_W-1:0] RST_DECAY_COEF      = 16'd655;
    localparam logic [CFG_DATA_W-1:0] RST_MARGIN_COEF     = 16'd9830;

    // Tracker and shown-axis reset values, integer units.
    localparam int RST_TRACK_HIGH_INT = 100;
    localparam logic signed [OUT_W-1:0] RST_SHOWN_LOW  = -26'sd100;
    localparam logic signed [OUT_W-1:0] RST_SHOWN_HIGH = 26'sd300;

    // Change threshold: shown span / 20 = floor(floor(span / 4) / 5).
    // The divide by five is a multiply by a rounded-up reciprocal.
    localparam int DIFF_W    = OUT_W + 1;
    localparam int THR_X_W   = DIFF_W - 2;
    localparam int THR_SHIFT = THR_X_W + 2;
    localparam int THR_P_W   = 2 * THR_X_W;
    localparam int THR_W     = THR_P_W - THR_SHIFT;
    localparam logic [THR_X_W-1:0] THR_MUL = THR_X_W'((2 ** THR_SHIFT + 4) / 5);

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXPAND,
        ST_CENTER,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_APPLY_HI,
        ST_FORCE,
        ST_MARGIN,
        ST_CAND,
        ST_DECIDE
    } arng_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_sample;
        logic expand;
        logic center;
        logic mul_lo;
        logic mul_hi;
        logic apply_hi;
        logic force_span;
        logic margin;
        logic cand;
        logic decide;
    } arng_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic seeded;
    } arng_stat_t;

endpackage

>>> design/auto_range_tracker.sv
// Auto-ranging display axis: top level with stream and configuration ports.
//
// Usage:
//   Samples enter on the s_ side, one signed sample per word in s_tdata.
//   For every sample one result word leaves on the m_ side: the lower and
//   upper axis bounds currently shown in m_tdata and a changed flag in
//   m_tuser that is set when this sample moved the shown bounds.
//   Registers are written over cfg_valid/cfg_ready/cfg_index/cfg_data
//   while no sample is in flight; cfg_ready is always high.
// Timing:
//   One sample is in work at a time: a new sample is taken only after the
//   sequencer has stepped through its steps for the last one, using the
//   shared Q0.16 multiplier for decay and margin work (the first sample
//   after reset, which seeds the tracker, skips the decay steps).
// Reset and stall:
//   Reset restores the register defaults and the initial axis, and makes
//   the next sample a seed. If the receiver stalls, the result word holds;
//   the next sample is still taken and processed, and waits in its last
//   step until the held word is read.
module auto_range_tracker
#(
    parameter int SAMPLE_BITS = 24,
    parameter int FRAC_BITS   = 8
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    // s_tdata: sample [SAMPLE_BITS-1:0]
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    // m_tdata: axis_low [25:0], axis_high [51:26], zero fill [55:52]
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    output logic [arng_pkg::OUT_TDATA_W-1:0]        m_tdata,
    // m_tuser: axis_changed [0]
    output logic                                    m_tuser,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [arng_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [arng_pkg::CFG_DATA_W-1:0]         cfg_data
);

    localparam int FILL_W = arng_pkg::OUT_TDATA_W - 2 * arng_pkg::OUT_W;

    arng_pkg::arng_cmd_t               cmd;
    arng_pkg::arng_stat_t              stat;
    logic signed [arng_pkg::OUT_W-1:0] axis_low;
    logic signed [arng_pkg::OUT_W-1:0] axis_high;
    logic                              axis_changed;

    assign cfg_ready = 1'b1;

    // Sequencer.
    arng_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Datapath.
    arng_dp
    #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    )
    u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample       ($signed(s_tdata[SAMPLE_BITS-1:0])),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .stat         (stat),
        .axis_low     (axis_low),
        .axis_high    (axis_high),
        .axis_changed (axis_changed)
    );

    // Result word packing.
    assign m_tdata = {{FILL_W{1'b0}}, axis_high, axis_low};
    assign m_tuser = axis_changed;

endmodule

>>> design/arng_ctrl.sv
// Sequencing controller of the auto-ranging axis tracker.
module arng_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  arng_pkg::arng_stat_t stat,
    output arng_pkg::arng_cmd_t  cmd
);

    arng_pkg::arng_state_t state_reg;
    arng_pkg::arng_state_t state_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  load_out;

    // State and output-valid registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= arng_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // The result slot frees when the receiver takes the word.
    assign load_out = !out_valid_reg || out_ready;

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            arng_pkg::ST_IDLE:
            begin
                in_ready        = 1'b1;
                cmd.load_sample = in_valid;
                if (in_valid)
                begin
                    state_next = arng_pkg::ST_EXPAND;
                end
            end
            arng_pkg::ST_EXPAND:
            begin
                cmd.expand = 1'b1;
                // The first sample seeds the bounds and skips the decay steps.
                state_next = stat.seeded ? arng_pkg::ST_CENTER : arng_pkg::ST_FORCE;
            end
            arng_pkg::ST_CENTER:
            begin
                cmd.center = 1'b1;
                state_next = arng_pkg::ST_MUL_LO;
            end
            arng_pkg::ST_MUL_LO:
            begin
                cmd.mul_lo = 1'b1;
                state_next = arng_pkg::ST_MUL_HI;
            end
            arng_pkg::ST_MUL_HI:
            begin
                cmd.mul_hi = 1'b1;
                state_next = arng_pkg::ST_APPLY_HI;
            end
            arng_pkg::ST_APPLY_HI:
            begin
                cmd.apply_hi = 1'b1;
                state_next   = arng_pkg::ST_FORCE;
            end
            arng_pkg::ST_FORCE:
            begin
                cmd.force_span = 1'b1;
                state_next     = arng_pkg::ST_MARGIN;
            end
            arng_pkg::ST_MARGIN:
            begin
                cmd.margin = 1'b1;
                state_next = arng_pkg::ST_CAND;
            end
            arng_pkg::ST_CAND:
            begin
                cmd.cand   = 1'b1;
                state_next = arng_pkg::ST_DECIDE;
            end
            arng_pkg::ST_DECIDE:
            begin
                // Wait here while the previous word is still unread.
                cmd.decide = load_out;
                if (load_out)
                begin
                    state_next = arng_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = arng_pkg::ST_IDLE;
            end
        endcase
    end

    // Output valid sets on a result load and clears when taken.
    always_comb
    begin
        if (cmd.decide)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    // An accepted sample always starts the expand step.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == arng_pkg::ST_EXPAND))
        else $error("accepted sample did not start processing");

    // A new result word appears only right after the decide step.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == arng_pkg::ST_DECIDE))
        else $error("result word raised outside the decide step");
`endif

endmodule

>>> design/arng_dp.sv
// Datapath of the auto-ranging axis tracker: bounds, shared multiplier, decision.
module arng_dp
#(
    parameter int SAMPLE_BITS = 24,
    parameter int FRAC_BITS   = 8
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic signed [SAMPLE_BITS-1:0]          sample,
    input  logic                                   cfg_we,
    input  logic [arng_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [arng_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  arng_pkg::arng_cmd_t                    cmd,
    output arng_pkg::arng_stat_t                   stat,
    output logic signed [arng_pkg::OUT_W-1:0]      axis_low,
    output logic signed [arng_pkg::OUT_W-1:0]      axis_high,
    output logic                                   axis_changed
);

    // Tracked bounds hold the sample range plus a 16-bit span, with two guard bits.
    localparam int TW = ((SAMPLE_BITS > 17) ? SAMPLE_BITS : 17) + FRAC_BITS + 2;
    localparam int PW = TW - 1;
    localparam int MW = PW + arng_pkg::COEF_W;
    localparam int YW = ((TW + 1) > (arng_pkg::OUT_W + 1)) ? (TW + 1) : (arng_pkg::OUT_W + 1);
    localparam int OW = arng_pkg::OUT_W;
    localparam int DW = arng_pkg::DIFF_W;

    localparam logic signed [TW-1:0] RND_ADD = TW'((1 << FRAC_BITS) - 1);
    localparam logic signed [TW-1:0] TRACK_HIGH_RST =
        TW'(arng_pkg::RST_TRACK_HIGH_INT) <<< FRAC_BITS;
    localparam logic signed [YW-1:0] Y_MAX = YW'((2 ** (OW - 1)) - 1);
    localparam logic signed [YW-1:0] Y_MIN = ~Y_MAX;

    // Configuration registers.
    logic [arng_pkg::CFG_DATA_W-1:0] start_half_span_reg;
    logic [arng_pkg::CFG_DATA_W-1:0] min_span_reg;
    logic [arng_pkg::CFG_DATA_W-1:0] decay_coef_reg;
    logic [arng_pkg::CFG_DATA_W-1:0] margin_coef_reg;

    // Tracker state.
    logic                     seeded_reg;
    logic signed [TW-1:0]     track_low_reg;
    logic signed [TW-1:0]     track_high_reg;
    logic signed [OW-1:0]     shown_low_reg;
    logic signed [OW-1:0]     shown_high_reg;

    // Working registers.
    logic signed [TW-1:0]            v_reg;
    logic signed [TW-1:0]            center_reg;
    logic signed [TW-1:0]            range_reg;
    logic [PW-1:0]                   prod_reg;
    logic [arng_pkg::THR_W-1:0]      thr_reg;
    logic signed [OW-1:0]            y_lo_reg;
    logic signed [OW-1:0]            y_hi_reg;
    logic                            changed_reg;

    // Combinational terms.
    logic signed [TW-1:0]            sample_ext;
    logic signed [TW-1:0]            half_start;
    logic signed [TW-1:0]            span;
    logic signed [TW:0]              sum_lh;
    logic signed [TW-1:0]            mid;
    logic signed [TW-1:0]            range_now;
    logic signed [TW-1:0]            low_force;
    logic signed [TW-1:0]            prod_s;
    logic signed [TW-1:0]            mul_a;
    logic [PW-1:0]                   mul_u;
    logic [arng_pkg::COEF_W-1:0]     mul_c;
    logic [MW-1:0]                   mul_full;
    logic signed [DW-1:0]            shown_diff;
    logic [arng_pkg::THR_P_W-1:0]    thr_full;
    logic signed [TW-1:0]            low_adj;
    logic signed [TW-1:0]            high_adj;
    logic signed [TW-1:0]            low_int;
    logic signed [TW-1:0]            high_int;
    logic [PW-1:0]                   margin;
    logic signed [YW-1:0]            y_lo_w;
    logic signed [YW-1:0]            y_hi_w;
    logic signed [DW-1:0]            d_lo;
    logic signed [DW-1:0]            d_hi;
    logic [DW-1:0]                   a_lo;
    logic [DW-1:0]                   a_hi;
    logic                            changed;

    // Clamp a candidate to the output range.
    function automatic logic signed [OW-1:0] sat_out(input logic signed [YW-1:0] y);
        logic signed [YW-1:0] r;
        begin
            r = y;
            if (y > Y_MAX)
            begin
                r = Y_MAX;
            end
            else if (y < Y_MIN)
            begin
                r = Y_MIN;
            end
            return r[OW-1:0];
        end
    endfunction

    // Input scaling and fixed-point spans.
    assign sample_ext = {{(TW - SAMPLE_BITS){sample[SAMPLE_BITS-1]}}, sample};
    assign half_start = $signed(TW'(start_half_span_reg) << FRAC_BITS);
    assign span       = $signed(TW'(min_span_reg) << FRAC_BITS);

    // Midpoint of the current bounds, rounded toward minus infinity.
    assign sum_lh = {track_low_reg[TW-1], track_low_reg} + {track_high_reg[TW-1], track_high_reg};
    assign mid    = sum_lh[TW:1];

    // Minimum-span forcing.
    assign range_now = track_high_reg - track_low_reg;
    assign low_force = mid - (span >>> 1);

    // Shared Q0.16 multiplier; a negative distance counts as zero.
    always_comb
    begin
        if (cmd.mul_lo)
        begin
            mul_a = center_reg - track_low_reg;
            mul_c = decay_coef_reg;
        end
        else if (cmd.mul_hi)
        begin
            mul_a = track_high_reg - center_reg;
            mul_c = decay_coef_reg;
        end
        else
        begin
            mul_a = range_reg;
            mul_c = margin_coef_reg;
        end
    end

    assign mul_u    = mul_a[TW-1] ? '0 : mul_a[PW-1:0];
    assign mul_full = MW'(mul_u) * MW'(mul_c);
    assign prod_s   = $signed({1'b0, prod_reg});

    // Change threshold from the span shown now.
    assign shown_diff = {shown_high_reg[OW-1], shown_high_reg}
                      - {shown_low_reg[OW-1], shown_low_reg};
    assign thr_full   = arng_pkg::THR_P_W'(shown_diff[DW-1:2])
                      * arng_pkg::THR_P_W'(arng_pkg::THR_MUL);

    // Candidate axis limits: bounds truncated toward zero, widened by the margin.
    assign low_adj  = track_low_reg + (track_low_reg[TW-1] ? RND_ADD : '0);
    assign high_adj = track_high_reg + (track_high_reg[TW-1] ? RND_ADD : '0);
    assign low_int  = low_adj >>> FRAC_BITS;
    assign high_int = high_adj >>> FRAC_BITS;
    assign margin   = prod_reg >> FRAC_BITS;
    assign y_lo_w   = {{(YW - TW){low_int[TW-1]}}, low_int} - $signed({{(YW - PW){1'b0}}, margin});
    assign y_hi_w   = {{(YW - TW){high_int[TW-1]}}, high_int} + $signed({{(YW - PW){1'b0}}, margin});

    // Publish decision.
    assign d_lo    = {y_lo_reg[OW-1], y_lo_reg} - {shown_low_reg[OW-1], shown_low_reg};
    assign d_hi    = {y_hi_reg[OW-1], y_hi_reg} - {shown_high_reg[OW-1], shown_high_reg};
    assign a_lo    = d_lo[DW-1] ? DW'(-d_lo) : DW'(d_lo);
    assign a_hi    = d_hi[DW-1] ? DW'(-d_hi) : DW'(d_hi);
    assign changed = (a_lo > DW'(thr_reg)) || (a_hi > DW'(thr_reg));

    // Configuration and tracker state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_half_span_reg <= arng_pkg::RST_START_HALF_SPAN;
            min_span_reg        <= arng_pkg::RST_MIN_SPAN;
            decay_coef_reg      <= arng_pkg::RST_DECAY_COEF;
            margin_coef_reg     <= arng_pkg::RST_MARGIN_COEF;
            seeded_reg          <= 1'b0;
            track_low_reg       <= '0;
            track_high_reg      <= TRACK_HIGH_RST;
            shown_low_reg       <= arng_pkg::RST_SHOWN_LOW;
            shown_high_reg      <= arng_pkg::RST_SHOWN_HIGH;
        end
        else
        begin
            if (cfg_we)
            begin
                case (arng_pkg::cfg_reg_t'(cfg_index))
                    arng_pkg::CFG_START_HALF_SPAN: start_half_span_reg <= cfg_data;
                    arng_pkg::CFG_MIN_SPAN:        min_span_reg        <= cfg_data;
                    arng_pkg::CFG_DECAY_COEF:      decay_coef_reg      <= cfg_data;
                    arng_pkg::CFG_MARGIN_COEF:     margin_coef_reg     <= cfg_data;
                    default:                       start_half_span_reg <= start_half_span_reg;
                endcase
            end

            // Seed on the first sample, otherwise expand at once.
            if (cmd.expand)
            begin
                seeded_reg <= 1'b1;
                if (!seeded_reg)
                begin
                    track_low_reg  <= v_reg - half_start;
                    track_high_reg <= v_reg + half_start;
                end
                else
                begin
                    if (v_reg < track_low_reg)
                    begin
                        track_low_reg <= v_reg;
                    end
                    if (v_reg > track_high_reg)
                    begin
                        track_high_reg <= v_reg;
                    end
                end
            end

            // Decay: the low bound moves up, then the high bound moves down.
            if (cmd.mul_hi)
            begin
                track_low_reg <= track_low_reg + prod_s;
            end
            if (cmd.apply_hi)
            begin
                track_high_reg <= track_high_reg - prod_s;
            end

            // Force the span up to the minimum about its midpoint.
            if (cmd.force_span && (range_now < span))
            begin
                track_low_reg  <= low_force;
                track_high_reg <= low_force + span;
            end

            if (cmd.decide && changed)
            begin
                shown_low_reg  <= y_lo_reg;
                shown_high_reg <= y_hi_reg;
            end
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load_sample)
        begin
            v_reg <= sample_ext <<< FRAC_BITS;
        end
        if (cmd.center)
        begin
            center_reg <= mid;
        end
        if (cmd.mul_lo || cmd.mul_hi || cmd.margin)
        begin
            prod_reg <= mul_full[MW-1:arng_pkg::COEF_W];
        end
        if (cmd.force_span)
        begin
            range_reg <= (range_now < span) ? span : range_now;
        end
        if (cmd.margin)
        begin
            thr_reg <= thr_full[arng_pkg::THR_SHIFT +: arng_pkg::THR_W];
        end
        if (cmd.cand)
        begin
            y_lo_reg <= sat_out(y_lo_w);
            y_hi_reg <= sat_out(y_hi_w);
        end
        if (cmd.decide)
        begin
            changed_reg <= changed;
        end
    end

    // The shown bounds only change when a result word loads, so they drive the output.
    assign axis_low     = shown_low_reg;
    assign axis_high    = shown_high_reg;
    assign axis_changed = changed_reg;
    assign stat.seeded  = seeded_reg;

`ifndef SYNTHESIS
    // Once seeded, the tracker never returns to the unseeded state.
    assert property (@(posedge clk) disable iff (!rst_n)
        seeded_reg |=> seeded_reg)
        else $error("seeded flag dropped");

    // Tracked bounds stay ordered when candidates are formed.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.cand && seeded_reg) |-> (track_high_reg >= track_low_reg))
        else $error("tracked bounds crossed");

    // The shown axis is never inverted.
    assert property (@(posedge clk) disable iff (!rst_n)
        shown_high_reg >= shown_low_reg)
        else $error("shown axis inverted");
`endif

endmodule

>>> tb/auto_range_tracker_test.sv
// Self-checking testbench for the auto-ranging axis tracker.
`timescale 1ns / 100ps

module auto_range_tracker_test;

    import arng_pkg::*;

    localparam int SAMPLE_W        = 24;
    localparam int FRAC_W          = 8;
    localparam int S_TDATA_W       = ((SAMPLE_W + 7) / 8) * 8;
    localparam int TRACK_W         = 34;
    localparam int SHOWN_SPAN_DIV  = 20;
    localparam int RESET_CYCLES    = 11;
    localparam int IDLE_PCT        = 7;
    localparam int MAX_GAP         = 12;
    localparam int RAND_PHASES     = 8;
    localparam int ITEMS_PER_PHASE = 212;
    localparam int QUIET_PHASE     = 3;
    localparam int SETTLE_CYCLES   = 20;
    localparam int MAX_REPORTS     = 50;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int STIM_ROWS       = 27;

    localparam logic signed [SAMPLE_W-1:0] SMP_MAX = 24'sh7FFFFF;
    localparam logic signed [SAMPLE_W-1:0] SMP_MIN = 24'sh800000;
    localparam longint AXIS_MAX = (longint'(1) << (OUT_W - 1)) - 1;
    localparam longint AXIS_MIN = -(longint'(1) << (OUT_W - 1));

    // One result word: shown axis bounds and the changed flag.
    typedef struct packed {
        logic signed [OUT_W-1:0] lo;
        logic signed [OUT_W-1:0] hi;
        logic                    chg;
    } axis_word_t;

    // Kinds of rows in the directed stimulus table.
    typedef enum logic [1:0] {
        ROW_SAMPLE,
        ROW_KNOWN,
        ROW_CFG
    } plan_kind_t;

    typedef struct packed {
        plan_kind_t                 kind;
        cfg_reg_t                   sel;
        logic [CFG_DATA_W-1:0]      val;
        logic signed [SAMPLE_W-1:0] smp;
        axis_word_t                 known;
    } plan_row_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    bit          no_idle        = 1'b0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;

    // Expected result words, oldest first.
    axis_word_t axis_expect_q[$];

    // Mirror of the tracker registers and state.
    logic [CFG_DATA_W-1:0]     half_span_reg = RST_START_HALF_SPAN;
    logic [CFG_DATA_W-1:0]     min_span_reg  = RST_MIN_SPAN;
    logic [CFG_DATA_W-1:0]     decay_reg     = RST_DECAY_COEF;
    logic [CFG_DATA_W-1:0]     margin_reg    = RST_MARGIN_COEF;
    bit                        seeded        = 1'b0;
    logic signed [TRACK_W-1:0] trk_lo        = '0;
    logic signed [TRACK_W-1:0] trk_hi        = TRACK_W'(longint'(RST_TRACK_HIGH_INT) << FRAC_W);
    logic signed [OUT_W-1:0]   shown_lo      = RST_SHOWN_LOW;
    logic signed [OUT_W-1:0]   shown_hi      = RST_SHOWN_HIGH;

    // Directed part: extremes of the sample, every register at its limits,
    // a collapsed span with no minimum span, and the seed after reset.
    plan_row_t stim_plan [STIM_ROWS] = '{
        '{ROW_KNOWN,  CFG_START_HALF_SPAN, 16'd0,     24'sd0,      '{-26'sd64, 26'sd64, 1'b1}},
        '{ROW_KNOWN,  CFG_START_HALF_SPAN, 16'd0,     24'sd0,      '{-26'sd64, 26'sd64, 1'b0}},
        '{ROW_SAMPLE, CFG_START_HALF_SPAN, 16'd0,     SMP_MAX,     '0},
        '{ROW_SAMPLE, CFG_START_HALF_SPAN, 16'd0,     SMP_MIN,     '0},
        '{ROW_SAMPLE, CFG_START_HALF_SPAN, 16'd0,     SMP_MIN,     '0},
        '{ROW_CFG,    CFG_DECAY_COEF,      16'hFFFF,  24'sd0,      '0},
        '{ROW_SAMPLE, CFG_START_HALF_SPAN, 16'd0,     24'sd1000,   '0},
        '{ROW_SAMPLE, CFG_START_HALF_SPAN, 16'd0,     -24'sd1,     '0},
        '{ROW_CFG,    CFG_DECAY_COEF,      16'd0,     24'sd0,      '0},
        '{ROW_SAMPLE, CFG_START_HALF_SPAN, 16'd0,     SMP_MAX,     '0},
        '{ROW_SAMPLE, CFG_START_HALF_SPAN, 16'd0,     SMP_MIN,     '0},
        '{ROW_CFG,    CFG_MARGIN_COEF,     16'd0,     24'sd0,      '0},
        '{ROW_SAMPLE, CFG_START_HALF_SPAN, 16'd0,     24'sd0,      '0},
        '{ROW_CFG,    CFG_MARGIN_COEF,     16'hFFFF,  24'sd0,      '0},
        '{ROW_SAMPLE, CFG_START_HALF_SPAN, 16'd0,     SMP_MAX,     '0},
        '{ROW_CFG,    CFG_MIN_SPAN,        16'd0,     24'sd0,      '0},
        '{ROW_CFG,    CFG_DECAY_COEF,      16'hFFFF,  24'sd0,      '0},
        '{ROW_SAMPLE, CFG_START_HALF_SPAN, 16'd0,     24'sd5,      '0},
        '{ROW_SAMPLE, CFG_START_HALF_SPAN, 16'd0,     24'sd5,      '0},
        '{ROW_SAMPLE, CFG_START_HALF_SPAN, 16'd0,     -24'sd5,     '0},
        '{ROW_CFG,    CFG_MIN_SPAN,        16'hFFFF,  24'sd0,      '0},
        '{ROW_SAMPLE, CFG_START_HALF_SPAN, 16'd0,     -24'sd3,     '0},
        '{ROW_SAMPLE, CFG_START_HALF_SPAN, 16'd0,     SMP_MAX,     '0},
        '{ROW_CFG,    CFG_START_HALF_SPAN, 16'hFFFF,  24'sd0,      '0},
        '{ROW_SAMPLE, CFG_START_HALF_SPAN, 16'd0,     24'sd0,      '0},
        '{ROW_CFG,    CFG_START_HALF_SPAN, 16'd0,     24'sd0,      '0},
        '{ROW_SAMPLE, CFG_START_HALF_SPAN, 16'd0,     24'sd123456, '0}
    };

    auto_range_tracker
    #(
        .SAMPLE_BITS (SAMPLE_W),
        .FRAC_BITS   (FRAC_W)
    )
    i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock, 8 ns period.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Fraction in Q0.16 of a nonnegative distance, floored; nothing below zero.
    function automatic longint scale_q16(input longint x, input logic [COEF_W-1:0] c);
        if (x <= 0)
            return 0;
        return (x * longint'(c)) >>> 16;
    endfunction

    // Drop the fractional bits, rounding toward zero.
    function automatic longint toward_zero(input longint x);
        if (x < 0)
            return -((-x) >> FRAC_W);
        return x >> FRAC_W;
    endfunction

    function automatic longint clip_axis(input longint x);
        if (x > AXIS_MAX)
            return AXIS_MAX;
        if (x < AXIS_MIN)
            return AXIS_MIN;
        return x;
    endfunction

    // Advance the tracker by one sample and return the word it should emit.
    function automatic axis_word_t track_sample(input logic signed [SAMPLE_W-1:0] smp);
        longint     v;
        longint     lo;
        longint     hi;
        longint     ctr;
        longint     span;
        longint     rng;
        longint     mrg;
        longint     y_lo;
        longint     y_hi;
        longint     thr;
        longint     d_lo;
        longint     d_hi;
        axis_word_t res;
        v  = longint'(smp) * (longint'(1) << FRAC_W);
        lo = trk_lo;
        hi = trk_hi;

        // The first sample seeds the bounds; later ones widen, then decay.
        if (!seeded)
        begin
            lo = v - (longint'(half_span_reg) << FRAC_W);
            hi = v + (longint'(half_span_reg) << FRAC_W);
            seeded = 1'b1;
        end
        else
        begin
            if (v < lo)
                lo = v;
            if (v > hi)
                hi = v;
            ctr = (lo + hi) >>> 1;
            lo = lo + scale_q16(ctr - lo, decay_reg);
            hi = hi - scale_q16(hi - ctr, decay_reg);
        end

        // Enforce the minimum span about the center.
        span = longint'(min_span_reg) << FRAC_W;
        rng  = hi - lo;
        if (rng < span)
        begin
            ctr = (lo + hi) >>> 1;
            lo  = ctr - span / 2;
            hi  = lo + span;
            rng = span;
        end
        trk_lo = TRACK_W'(lo);
        trk_hi = TRACK_W'(hi);

        // Candidate axis with margin, published only past the threshold.
        mrg  = toward_zero(scale_q16(rng, margin_reg));
        y_lo = clip_axis(toward_zero(lo) - mrg);
        y_hi = clip_axis(toward_zero(hi) + mrg);
        thr  = (longint'(shown_hi) - longint'(shown_lo)) / SHOWN_SPAN_DIV;
        d_lo = y_lo - longint'(shown_lo);
        d_hi = y_hi - longint'(shown_hi);
        if (d_lo < 0)
            d_lo = -d_lo;
        if (d_hi < 0)
            d_hi = -d_hi;
        res.chg = (d_lo > thr) || (d_hi > thr);
        if (res.chg)
        begin
            shown_lo = OUT_W'(y_lo);
            shown_hi = OUT_W'(y_hi);
        end
        res.lo = shown_lo;
        res.hi = shown_hi;
        return res;
    endfunction

    // Register value: an extreme, anything, or something in the usual range.
    function automatic logic [CFG_DATA_W-1:0] pick_reg(input logic [CFG_DATA_W-1:0] usual_max);
        case ($urandom_range(5))
            0:       return '0;
            1:       return '1;
            2:       return CFG_DATA_W'($urandom());
            default: return CFG_DATA_W'($urandom_range(usual_max));
        endcase
    endfunction

    // Write one register once no sample is in flight.
    task automatic write_reg(input cfg_reg_t sel, input logic [CFG_DATA_W-1:0] val);
        s_tvalid <= 1'b0;
        while (axis_expect_q.size() != 0)
            @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (sel)
            CFG_START_HALF_SPAN: half_span_reg = val;
            CFG_MIN_SPAN:        min_span_reg  = val;
            CFG_DECAY_COEF:      decay_reg     = val;
            CFG_MARGIN_COEF:     margin_reg    = val;
            default:             ;
        endcase
    endtask

    // Offer one sample word, with an occasional gap ahead of it.
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] smp, input bit known,
                               input axis_word_t known_word);
        axis_word_t predicted;
        cfg_valid <= 1'b0;
        if (!no_idle && $urandom_range(99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, MAX_GAP)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'($unsigned(smp));
        do
            @(posedge clk);
        while (!s_tready);
        predicted = track_sample(smp);
        axis_expect_q.push_back(known ? known_word : predicted);
    endtask

    // Result side: random stalls except in the quiet phase.
    always @(posedge clk)
        m_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);

    // Compare each result word with the oldest expectation.
    always @(posedge clk)
    begin : result_check
        axis_word_t got;
        axis_word_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.lo  = m_tdata[OUT_W-1:0];
            got.hi  = m_tdata[2*OUT_W-1:OUT_W];
            got.chg = m_tuser;
            if (axis_expect_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: unexpected result word, actual %0d %0d %0d", $time,
                             $signed(got.lo), $signed(got.hi), got.chg);
            end
            else
            begin
                want = axis_expect_q.pop_front();
                if (got.lo !== want.lo)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: axis_low mismatch, expected %0d, actual %0d", $time,
                                 $signed(want.lo), $signed(got.lo));
                end
                if (got.hi !== want.hi)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: axis_high mismatch, expected %0d, actual %0d", $time,
                                 $signed(want.hi), $signed(got.hi));
                end
                if (got.chg !== want.chg)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: axis_changed mismatch, expected %0d, actual %0d",
                                 $time, want.chg, got.chg);
                end
            end
        end
    end

    // Watchdog on the total run length.
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    // Reset, directed table, then random phases.
    initial
    begin : stimulus
        int unsigned                k;
        int unsigned                ph;
        int unsigned                n;
        int unsigned                r;
        int                         amp_log;
        longint                     base;
        longint                     raw;
        logic signed [SAMPLE_W-1:0] smp;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (k = 0; k < STIM_ROWS; k++)
        begin
            case (stim_plan[k].kind)
                ROW_CFG:    write_reg(stim_plan[k].sel, stim_plan[k].val);
                ROW_KNOWN:  send_sample(stim_plan[k].smp, 1'b1, stim_plan[k].known);
                ROW_SAMPLE: send_sample(stim_plan[k].smp, 1'b0, '0);
                default:    ;
            endcase
        end

        // Each phase: new register set, then a wandering signal with a random
        // baseline and amplitude, mixed with noise and full-scale spikes.
        base    = 0;
        amp_log = 0;
        for (ph = 0; ph < RAND_PHASES; ph++)
        begin
            write_reg(CFG_START_HALF_SPAN, pick_reg(16'hFFFF));
            write_reg(CFG_MIN_SPAN, pick_reg(16'd500));
            write_reg(CFG_DECAY_COEF, pick_reg(16'd2000));
            write_reg(CFG_MARGIN_COEF, pick_reg(16'd20000));
            no_idle = (ph == QUIET_PHASE);
            for (n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                r = $urandom_range(99);
                if (n == 0 || $urandom_range(49) == 0)
                begin
                    smp     = SAMPLE_W'($urandom());
                    base    = smp;
                    amp_log = $urandom_range(SAMPLE_W - 1);
                end
                if (r < 80)
                begin
                    raw = base + longint'($urandom_range(1 << (amp_log + 1)))
                          - (longint'(1) << amp_log);
                    if (raw > longint'(SMP_MAX))
                        raw = SMP_MAX;
                    if (raw < longint'(SMP_MIN))
                        raw = SMP_MIN;
                    smp = SAMPLE_W'(raw);
                end
                else if (r < 92)
                    smp = SAMPLE_W'($urandom());
                else if (r < 96)
                    smp = SMP_MAX;
                else
                    smp = SMP_MIN;
                send_sample(smp, 1'b0, '0);
            end
            no_idle = 1'b0;
        end

        // Drain and let any stray word show up before the verdict.
        s_tvalid <= 1'b0;
        while (axis_expect_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && axis_expect_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
